// ===== sv/spd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair de-duplication package
// Shared field widths, command and verdict codes, and the transaction types
// that travel between the front end, the back end and the result queue.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int ID_W      = 8;
  localparam int CNT_W     = 9;
  localparam int VERDICT_W = 3;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 9'd10;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 9'd511;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_PAIR  = 1'b1;

  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT         = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE      = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_SELF           = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_LOWER_UNLISTED = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_REVERSE_HELD   = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_LIMIT          = 3'd5;
  localparam logic [VERDICT_W-1:0] VERDICT_CLEARED        = 3'd6;

  // Input transaction after classification by the front end.
  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] image_id;
    logic [ID_W-1:0] match_id;
    logic            is_self;
    logic            is_lower;
  } item_t;

  // Result transaction.
  typedef struct packed {
    logic [ID_W-1:0]      pair_image;
    logic [ID_W-1:0]      pair_match;
    logic [VERDICT_W-1:0] verdict;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/spd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair de-duplication front end
// Accepts input transactions, classifies the pair (self, lower) and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module spd_front import spd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            command,
  input  wire logic [ID_W-1:0] image_id,
  input  wire logic [ID_W-1:0] match_id,
  input  wire logic            sweep,
  output logic                 out_valid,
  output item_t                out_item,
  input  wire logic            out_take
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  item_t      new_item;

  // The back end accepts nothing while it sweeps the stores.
  assign full      = (count == 2'd2) || sweep;
  assign accept    = push && !full;
  assign out_valid = (count != 2'd0);
  assign out_item  = entries[rd_ptr];

  always_comb begin
    new_item.cmd      = command;
    new_item.image_id = image_id;
    new_item.match_id = match_id;
    new_item.is_self  = (match_id == image_id);
    new_item.is_lower = (match_id < image_id);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (out_take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({accept, out_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/spd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair de-duplication back end
// Owns the pair bit store and the listed marks, sweeps them clear, and runs
// each candidate through a read step and a decide-and-write step.
// ----------------------------------------------------------------------------
module spd_back import spd_pkg::*; #(
  parameter int MAX_IMAGES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_limit,
  input  wire logic             in_valid,
  input  wire item_t            in_item,
  output logic                  in_take,
  input  wire logic             rq_full,
  output logic                  res_push,
  output result_t               res,
  output logic                  sweep
);

  localparam int SW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int ID_VALUES = 1 << ID_W;
  localparam logic [SW-1:0] LAST_ROW = SW'(MAX_IMAGES - 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  // Identifier to store slot, identifier modulo MAX_IMAGES.
  logic [SW-1:0] slot_tab [ID_VALUES];
  for (genvar g = 0; g < ID_VALUES; g++) begin : g_slot
    assign slot_tab[g] = SW'(g % MAX_IMAGES);
  end

  logic [MAX_IMAGES-1:0] pair_mem   [MAX_IMAGES];
  logic                  listed_mem [MAX_IMAGES];

  logic [1:0]            state;
  logic [SW-1:0]         clr_idx;
  logic [ID_W-1:0]       current_image;
  logic [CNT_W-1:0]      found_count;
  logic                  job_started;
  logic [CNT_W-1:0]      match_limit;

  item_t                 work;
  logic [SW-1:0]         img_slot;
  logic [SW-1:0]         mat_slot;
  logic [MAX_IMAGES-1:0] rev_row;
  logic [MAX_IMAGES-1:0] fwd_row;
  logic                  listed_rd;

  logic                  issue;
  logic                  clr_cmd;
  logic                  exec;
  logic                  first;
  logic                  grp_new;
  logic [CNT_W-1:0]      cnt_eff;
  logic [CNT_W-1:0]      cnt_next;
  logic                  at_limit;
  logic                  listed_eff;
  logic                  pass;
  logic [VERDICT_W-1:0]  verdict;
  logic [MAX_IMAGES-1:0] new_row;
  logic                  pair_we;
  logic [SW-1:0]         pair_wa;
  logic [MAX_IMAGES-1:0] pair_wd;
  logic                  listed_we;

  assign sweep   = (state == ST_CLR);
  assign exec    = (state == ST_EXEC);
  assign in_take = (state == ST_IDLE) && in_valid && !rq_full;
  assign issue   = in_take && (in_item.cmd == CMD_PAIR);
  assign clr_cmd = in_take && (in_item.cmd == CMD_CLEAR);

  always_comb begin
    first      = !job_started;
    grp_new    = first || (work.image_id != current_image);
    cnt_eff    = grp_new ? '0 : found_count;
    at_limit   = (match_limit != '0) && (cnt_eff >= match_limit);
    // The first image marks itself listed before its own check.
    listed_eff = listed_rd || (first && (mat_slot == img_slot));
    pass       = 1'b0;
    if (at_limit) begin
      verdict = VERDICT_LIMIT;
    end else if (work.is_self) begin
      verdict = VERDICT_SELF;
    end else if (work.is_lower && !listed_eff) begin
      verdict = VERDICT_LOWER_UNLISTED;
    end else if (work.is_lower && rev_row[img_slot]) begin
      verdict = VERDICT_REVERSE_HELD;
    end else begin
      pass    = 1'b1;
      verdict = fwd_row[mat_slot] ? VERDICT_DUPLICATE : VERDICT_ACCEPT;
    end
    cnt_next = cnt_eff;
    if (pass && (cnt_eff != COUNT_MAX)) begin
      cnt_next = cnt_eff + 1'b1;
    end
    new_row           = fwd_row;
    new_row[mat_slot] = 1'b1;
  end

  always_comb begin
    pair_we   = sweep || (exec && pass);
    pair_wa   = sweep ? clr_idx : img_slot;
    pair_wd   = sweep ? '0 : new_row;
    listed_we = sweep || (exec && (pass || first));
  end

  always_comb begin
    res_push = clr_cmd || exec;
    if (clr_cmd) begin
      res.pair_image = in_item.image_id;
      res.pair_match = in_item.match_id;
      res.verdict    = VERDICT_CLEARED;
    end else begin
      res.pair_image = work.image_id;
      res.pair_match = work.match_id;
      res.verdict    = verdict;
    end
  end

  // Stores: one write port, reads registered.
  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    if (listed_we) begin
      listed_mem[pair_wa] <= !sweep;
    end
    if (issue) begin
      rev_row   <= pair_mem[slot_tab[in_item.match_id]];
      fwd_row   <= pair_mem[slot_tab[in_item.image_id]];
      listed_rd <= listed_mem[slot_tab[in_item.match_id]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      work     <= in_item;
      img_slot <= slot_tab[in_item.image_id];
      mat_slot <= slot_tab[in_item.match_id];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      match_limit <= cfg_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_idx       <= '0;
      current_image <= '0;
      found_count   <= '0;
      job_started   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLR: begin
          if (clr_idx == LAST_ROW) begin
            clr_idx <= '0;
            state   <= ST_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (clr_cmd) begin
            current_image <= '0;
            found_count   <= '0;
            job_started   <= 1'b0;
            state         <= ST_CLR;
          end else if (issue) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          job_started   <= 1'b1;
          current_image <= work.image_id;
          found_count   <= cnt_next;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/spd_rq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair de-duplication result queue
// Two-entry queue that holds finished results until they are popped.
// ----------------------------------------------------------------------------
module spd_rq import spd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_push,
  input  wire result_t res,
  output logic         rq_full,
  output logic         empty,
  input  wire logic    pop,
  output result_t      head
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;

  assign rq_full = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign take    = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      entries[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({res_push, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/symmetric_pair_dedup_top_k.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Symmetric pair de-duplication with per-image top-k limit
// Gives a verdict on each candidate (image, match) pair and records accepted
// pairs so that the reverse pair of an already listed image is rejected.
// ----------------------------------------------------------------------------
// In the back end, taking a candidate transaction reads the forward row,
// the reverse row and the listed mark of the match into registers, and the
// next cycle decides the verdict and writes the updated row back to the
// same pair store. A new candidate is taken only after that write and only
// while the result queue is not full; a clear command returns its result
// at once. After reset and after every clear command the back end sweeps
// the pair store and the listed marks one row per cycle, rows 0 through
// MAX_IMAGES-1, and full stays high for that whole sweep; match_limit
// writes are still taken during it. The input side is a two-entry queue
// and the result side another, so one waiting result does not stop the
// back end; a full result queue stalls the back end, and the input side
// then fills its two entries before full rises.
// Identifiers address the stores modulo MAX_IMAGES, while the self and
// lower comparisons use the full eight-bit identifiers. match_limit may be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module symmetric_pair_dedup_top_k import spd_pkg::*; #(
  parameter int MAX_IMAGES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration: a write enable and the new limit value.
  input  wire logic                 cfg_we,
  input  wire logic [CNT_W-1:0]     match_limit,
  // Input queue side.
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 command,
  input  wire logic [ID_W-1:0]      image_id,
  input  wire logic [ID_W-1:0]      match_id,
  // Result queue side.
  output logic                      empty,
  input  wire logic                 pop,
  output logic [ID_W-1:0]           pair_image,
  output logic [ID_W-1:0]           pair_match,
  output logic [VERDICT_W-1:0]      verdict
);

  item_t   q_item;
  logic    q_valid;
  logic    q_take;
  logic    sweep;
  logic    rq_full;
  logic    res_push;
  result_t res;
  result_t head;

  // The front end classifies each transaction and queues it.
  spd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .image_id  (image_id),
    .match_id  (match_id),
    .sweep     (sweep),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_take  (q_take)
  );

  // The back end owns the stores and the per-group bookkeeping.
  spd_back #(
    .MAX_IMAGES (MAX_IMAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_limit (match_limit),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .in_take   (q_take),
    .rq_full   (rq_full),
    .res_push  (res_push),
    .res       (res),
    .sweep     (sweep)
  );

  // Finished results wait here until they are popped.
  spd_rq u_rq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .rq_full  (rq_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign pair_image = head.pair_image;
  assign pair_match = head.pair_match;
  assign verdict    = head.verdict;

endmodule
`default_nettype wire

// ===== sv/spd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair de-duplication port checker
// Concurrent checks on the top level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module spd_checker import spd_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 full,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire logic [ID_W-1:0]      pair_image,
  input wire logic [ID_W-1:0]      pair_match,
  input wire logic [VERDICT_W-1:0] verdict
);

  // A waiting result holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pair_image) && $stable(pair_match)
                          && $stable(verdict)))
    else $error("result changed while waiting");

  // Reset always starts a clearing sweep, so nothing is accepted next cycle.
  a_sweep: assert property (@(posedge clk) rst |=> full)
    else $error("input open right after reset");

  // The self verdict matches the echoed identifiers exactly.
  a_self: assert property (@(posedge clk) disable iff (rst)
    (!empty && verdict == VERDICT_SELF) |-> (pair_image == pair_match))
    else $error("self verdict on distinct identifiers");

  // Lower-unlisted and reverse-held verdicts only apply to lower matches.
  a_lower: assert property (@(posedge clk) disable iff (rst)
    (!empty && (verdict == VERDICT_LOWER_UNLISTED || verdict == VERDICT_REVERSE_HELD))
    |-> (pair_match < pair_image))
    else $error("lower verdict on a match that is not lower");

  // Only defined verdict codes leave the block.
  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (verdict <= VERDICT_CLEARED))
    else $error("undefined verdict code");

endmodule

bind symmetric_pair_dedup_top_k spd_checker u_spd_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .pair_image (pair_image),
  .pair_match (pair_match),
  .verdict    (verdict)
);
`default_nettype wire

// ===== bench/tb_symmetric_pair_dedup_top_k.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the symmetric pair de-duplication block
// Pushes clear commands and grouped candidate pairs through the input queue,
// predicts each verdict with a behavioral model of the pair store, the
// listed marks and the per-image count, and checks every popped result.
// ----------------------------------------------------------------------------
module tb_symmetric_pair_dedup_top_k import spd_pkg::*;;

  // Most of a correct run goes to the store sweep that follows every clear command.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 70;

  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] img;
    logic [ID_W-1:0] mat;
  } pair_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CNT_W-1:0]     limit_val = LIMIT_RESET;
  logic                 push = 1'b0;
  logic                 full;
  logic                 command = CMD_PAIR;
  logic [ID_W-1:0]      image_id = '0;
  logic [ID_W-1:0]      match_id = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [ID_W-1:0]      pair_image;
  logic [ID_W-1:0]      pair_match;
  logic [VERDICT_W-1:0] verdict;

  symmetric_pair_dedup_top_k dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .match_limit(limit_val),
    .push       (push),
    .full       (full),
    .command    (command),
    .image_id   (image_id),
    .match_id   (match_id),
    .empty      (empty),
    .pop        (pop),
    .pair_image (pair_image),
    .pair_match (pair_match),
    .verdict    (verdict)
  );

  initial forever #6 clk = ~clk;

  // Transactions waiting to be pushed, and verdicts waiting to be popped.
  pair_req_t   pending[$];
  result_t     verdicts_due[$];
  int unsigned queued_total = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_cnt = 0;

  // Both sides idle at random except in a recurring calm window, where
  // every cycle pushes and pops if it can.
  logic calm;
  assign calm = (cycle_cnt % 6000) >= 4200;

  // --------------------------------------------------------------------------
  // Behavioral model. Rather than wiping 64K pair bits on every clear, each
  // entry holds the number of the job that last set it; an entry counts as
  // set only when that number matches the current job.
  // --------------------------------------------------------------------------
  int unsigned      pair_epoch [0:65535];
  int unsigned      listed_epoch [0:255];
  int unsigned      job_epoch = 1;
  logic [ID_W-1:0]  group_image = '0;
  logic [CNT_W-1:0] group_count = '0;
  logic             job_open = 1'b0;
  logic [CNT_W-1:0] limit_model = LIMIT_RESET;

  initial begin
    foreach (pair_epoch[i]) pair_epoch[i] = 0;
    foreach (listed_epoch[i]) listed_epoch[i] = 0;
  end

  function automatic result_t judge_pair(input logic cmd, input logic [ID_W-1:0] img,
                                         input logic [ID_W-1:0] mat);
    result_t r;
    r.pair_image = img;
    r.pair_match = mat;
    if (cmd == CMD_CLEAR) begin
      job_epoch++;
      group_image = '0;
      group_count = '0;
      job_open = 1'b0;
      r.verdict = VERDICT_CLEARED;
      return r;
    end
    // The first image of a job holds a list from the start of its group.
    if (!job_open) begin
      job_open = 1'b1;
      group_image = img;
      group_count = '0;
      listed_epoch[img] = job_epoch;
    end else if (img != group_image) begin
      group_image = img;
      group_count = '0;
    end
    if (limit_model != 0 && group_count >= limit_model) begin
      r.verdict = VERDICT_LIMIT;
    end else if (mat == img) begin
      r.verdict = VERDICT_SELF;
    end else if (mat < img && listed_epoch[mat] != job_epoch) begin
      r.verdict = VERDICT_LOWER_UNLISTED;
    end else if (mat < img && pair_epoch[{mat, img}] == job_epoch) begin
      r.verdict = VERDICT_REVERSE_HELD;
    end else begin
      r.verdict = (pair_epoch[{img, mat}] == job_epoch) ? VERDICT_DUPLICATE
                                                         : VERDICT_ACCEPT;
      pair_epoch[{img, mat}] = job_epoch;
      listed_epoch[img] = job_epoch;
      if (group_count != COUNT_MAX) group_count++;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. A transaction completes at an edge where push is high and full
  // is low; its verdict is predicted right then, so the expectation queue
  // follows acceptance order. The next transaction is only loaded once the
  // current one is gone, which keeps push steady while full holds it back.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_pairs
    pair_req_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full)
        verdicts_due = {verdicts_due, judge_pair(command, image_id, match_id)};
      if (!push || !full) begin
        if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          nxt = pending.pop_front();
          command  <= nxt.cmd;
          image_id <= nxt.img;
          match_id <= nxt.mat;
          push     <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every popped result is matched against the oldest expectation,
  // field by field; only the first ten faults are printed.
  // --------------------------------------------------------------------------
  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : check_verdicts
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          note_fault($sformatf("unexpected result: image %0d match %0d verdict %0d",
                               pair_image, pair_match, verdict));
        end else begin
          want = verdicts_due.pop_front();
          if (pair_image !== want.pair_image || pair_match !== want.pair_match ||
              verdict !== want.verdict)
            note_fault($sformatf(
              "mismatch: got image %0d match %0d verdict %0d, want %0d %0d %0d",
              pair_image, pair_match, verdict,
              want.pair_image, want.pair_match, want.verdict));
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("symmetric_pair_dedup_top_k verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input logic cmd, input logic [ID_W-1:0] img,
                          input logic [ID_W-1:0] mat);
    pair_req_t req;
    req.cmd = cmd;
    req.img = img;
    req.mat = mat;
    pending = {pending, req};
    queued_total++;
  endtask

  // One job: a clear, then groups of candidates in rising image order drawn
  // from a narrow window of identifiers so that forward and reverse pairs
  // meet often. A few groups jump to any image of the window, and a small share
  // of transactions are stray full-range pairs or clears in mid-group.
  task automatic queue_job();
    int unsigned base, span, img, n, k, groups, roll;
    base = $urandom_range(0, 240);
    span = $urandom_range(3, 15);
    img = base + $urandom_range(0, 2);
    groups = 0;
    add_item(CMD_CLEAR, ID_W'($urandom_range(0, 255)), ID_W'($urandom_range(0, 255)));
    while (img <= base + span && groups < 20) begin
      n = $urandom_range(1, 14);
      for (k = 0; k < n; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          add_item(CMD_CLEAR, ID_W'($urandom_range(0, 255)),
                   ID_W'($urandom_range(0, 255)));
        else if (roll < 10)
          add_item(CMD_PAIR, ID_W'($urandom_range(0, 255)),
                   ID_W'($urandom_range(0, 255)));
        else
          add_item(CMD_PAIR, ID_W'(img), ID_W'(base + $urandom_range(0, span)));
      end
      groups++;
      if ($urandom_range(0, 9) == 0)
        img = base + $urandom_range(0, span);
      else
        img = img + $urandom_range(1, 3);
    end
  endtask

  task automatic queue_random_phase();
    int unsigned start;
    start = queued_total;
    while (queued_total - start < PHASE_ITEMS) queue_job();
  endtask

  // The sender holds off until every expected verdict is back; this is also
  // the idle point at which the limit register may change.
  task automatic drain_phase();
    do @(negedge clk);
    while (pending.size() != 0 || push || verdicts_due.size() != 0);
  endtask

  task automatic set_limit(input logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    limit_val <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_model = value;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed walk under the reset limit: a clear echoing all-ones fields,
    // a self match on the first image (which still counts as listed), a
    // lower match onto that first image, a lower match onto an unlisted
    // image, an accept followed by its duplicate, the reverse of an accepted
    // pair, identifiers at both ends of the range, and a group given out of
    // order.
    add_item(CMD_CLEAR, 8'd255, 8'd255);
    add_item(CMD_PAIR,  8'd5,   8'd5);
    add_item(CMD_PAIR,  8'd7,   8'd5);
    add_item(CMD_PAIR,  8'd7,   8'd3);
    add_item(CMD_PAIR,  8'd7,   8'd9);
    add_item(CMD_PAIR,  8'd7,   8'd9);
    add_item(CMD_PAIR,  8'd9,   8'd7);
    add_item(CMD_PAIR,  8'd9,   8'd255);
    add_item(CMD_PAIR,  8'd255, 8'd0);
    add_item(CMD_PAIR,  8'd255, 8'd9);
    add_item(CMD_PAIR,  8'd255, 8'd255);
    add_item(CMD_PAIR,  8'd0,   8'd255);
    add_item(CMD_PAIR,  8'd0,   8'd0);
    add_item(CMD_CLEAR, 8'd0,   8'd0);
    queue_random_phase();
    drain_phase();

    // A limit of one: the second candidate of a group is refused even when
    // it is a self match, and the reverse pair is still caught in the next
    // group.
    set_limit(9'd1);
    add_item(CMD_CLEAR, 8'd0, 8'd0);
    add_item(CMD_PAIR,  8'd3, 8'd4);
    add_item(CMD_PAIR,  8'd3, 8'd3);
    add_item(CMD_PAIR,  8'd3, 8'd5);
    add_item(CMD_PAIR,  8'd4, 8'd3);
    add_item(CMD_PAIR,  8'd4, 8'd6);
    add_item(CMD_PAIR,  8'd4, 8'd7);
    queue_random_phase();
    drain_phase();

    // Unlimited, a limit of 256, a small one, and one picked at random.
    set_limit(9'd0);
    queue_random_phase();
    drain_phase();

    set_limit(9'd256);
    queue_random_phase();
    drain_phase();

    set_limit(9'd3);
    queue_random_phase();
    drain_phase();

    set_limit(CNT_W'($urandom_range(0, 256)));
    queue_random_phase();
    drain_phase();

    // Let any stray result surface before the verdict is given.
    repeat (20) @(posedge clk);
    if (fault_count == 0)
      $display("symmetric_pair_dedup_top_k verification clean");
    else
      $display("symmetric_pair_dedup_top_k verification failed");
    $finish;
  end

endmodule
